### src/lsjs_pkg.sv
// Shared constants, types and tables of the laser scan jump segmenter.
`default_nettype none

package lsjs_pkg;

    // Field widths of the channels.
    localparam int RANGE_W    = 16;
    localparam int COORD_W    = 17;
    localparam int IDX_W      = 11;
    localparam int ANG_W      = 24;
    localparam int JUMP_W     = 32;
    localparam int MINP_W     = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Point store depth and CORDIC length.
    localparam int MAX_POINTS   = 2048;
    localparam int CORDIC_STEPS = 18;
    localparam int ATAN_N       = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int STEP_W       = $clog2(ATAN_N);

    // Point counter and a width that holds every count, index and threshold.
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int WIDE_A = (CNT_W > MINP_W) ? CNT_W : MINP_W;
    localparam int WIDE_W = (WIDE_A > IDX_W) ? WIDE_A : IDX_W;

    // CORDIC datapath widths: Q16 millimetres with headroom for the gain.
    localparam int XW = 36;
    localparam int ZW = 33;

    // Difference and square widths of the jump test.
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    localparam logic [31:0]        GAIN_Q32  = 32'd2608131496;
    localparam logic [RANGE_W-1:0] MIN_RANGE = RANGE_W'(20);
    localparam int                 MM_MAX    = 65535;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_DIST_SQ = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS   = CFG_IDX_W'(3);

    // Register values after reset.
    localparam logic [ANG_W-1:0]  RST_ANGLE_MIN    = ANG_W'(0);
    localparam logic [ANG_W-1:0]  RST_ANGLE_STEP   = ANG_W'(11651);
    localparam logic [JUMP_W-1:0] RST_JUMP_DIST_SQ = JUMP_W'(10000);
    localparam logic [MINP_W-1:0] RST_MIN_POINTS   = MINP_W'(3);

    // Result kinds.
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_SEG   = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [IDX_W-1:0]          idx_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Reported indices wrap at the index width.
    function automatic idx_t to_idx(input cnt_t v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/lsjs_if.sv
// Channel interfaces of the laser scan jump segmenter.
`default_nettype none

// Range samples in.
interface lsjs_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsjs_pkg::RANGE_W-1:0]  range_mm;
    logic                          range_valid;
    logic                          scan_end;

    modport source (output valid, output range_mm, output range_valid, output scan_end,
                    input ready);
    modport sink   (input valid, input range_mm, input range_valid, input scan_end,
                    output ready);
endinterface

// Points and closed segments out.
interface lsjs_out_if;
    logic                      valid;
    logic                      ready;
    logic                      result_kind;
    lsjs_pkg::coord_t          point_x;
    lsjs_pkg::coord_t          point_y;
    lsjs_pkg::idx_t            point_index;
    lsjs_pkg::idx_t            seg_first;
    lsjs_pkg::idx_t            seg_last;
    logic                      run_last;

    modport source (output valid, output result_kind, output point_x, output point_y,
                    output point_index, output seg_first, output seg_last,
                    output run_last, input ready);
    modport sink   (input valid, input result_kind, input point_x, input point_y,
                    input point_index, input seg_first, input seg_last,
                    input run_last, output ready);
endinterface

// Register writes.
interface lsjs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lsjs_pkg::CFG_IDX_W-1:0]  index;
    logic [lsjs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/laser_scan_jump_segmenter.sv
// Top level of the laser scan jump segmenter: registers, scan state, sequencer, output word.
//
//   channel   role   handshake      word
//   sample    sink   valid/ready    range_mm, range_valid, scan_end
//   result    source valid/ready    result_kind, point_x, point_y, point_index,
//                                   seg_first, seg_last, run_last
//   cfg       sink   valid/ready    index, data (ready is always high)
//
// A kept sample is accepted, then runs the CORDIC (start, gain multiply, one micro-rotation
// per step for 18 steps, rounding, hand-over), the jump test and the decision; its results
// then leave through the output register one at a time.
// The first kept point of a scan, or one on an axis, skips the jump test.
// A rejected sample goes to the decision, and to the output only when it closes a segment.
// Reset clears the scan state and loads the register defaults; there is no clearing pass.
// The block accepts the next sample once its last result sits in the output register;
// a stalled result holds that register and the sequencer waits for it.
`default_nettype none

module laser_scan_jump_segmenter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsjs_in_if.sink    sample,
    lsjs_out_if.source result,
    lsjs_cfg_if.sink   cfg
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORD   = 3'd1;
    localparam logic [2:0] S_JUMP   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam int WW = lsjs_pkg::WIDE_W;

    // Configuration registers.
    logic [lsjs_pkg::ANG_W-1:0]    angle_min_reg;
    logic [lsjs_pkg::ANG_W-1:0]    angle_step_reg;
    logic [lsjs_pkg::JUMP_W-1:0]   jump_dist_sq_reg;
    logic [lsjs_pkg::MINP_W-1:0]   min_points_reg;

    // Scan state.
    logic [lsjs_pkg::ANG_W-1:0]    angle_acc_reg;
    logic                          in_scan_reg;
    lsjs_pkg::coord_t              prev_x_reg;
    lsjs_pkg::coord_t              prev_y_reg;
    lsjs_pkg::cnt_t                kept_count_reg;
    lsjs_pkg::cnt_t                seg_start_reg;

    // Work on the current sample.
    logic [2:0]                    state_reg;
    logic [lsjs_pkg::RANGE_W-1:0]  range_reg;
    logic [lsjs_pkg::ANG_W-1:0]    theta_reg;
    logic                          kept_reg;
    logic                          end_reg;
    logic                          jump_reg;
    logic                          cord_start_reg;
    logic                          jump_start_reg;
    lsjs_pkg::coord_t              pt_x_reg;
    lsjs_pkg::coord_t              pt_y_reg;
    lsjs_pkg::idx_t                pt_idx_reg;
    lsjs_pkg::idx_t                jfirst_reg;
    lsjs_pkg::idx_t                jlast_reg;
    lsjs_pkg::idx_t                efirst_reg;
    lsjs_pkg::idx_t                elast_reg;
    logic [2:0]                    pend_reg;

    // Output word.
    logic                          out_valid_reg;
    logic                          out_kind_reg;
    lsjs_pkg::coord_t              out_x_reg;
    lsjs_pkg::coord_t              out_y_reg;
    lsjs_pkg::idx_t                out_idx_reg;
    lsjs_pkg::idx_t                out_first_reg;
    lsjs_pkg::idx_t                out_last_reg;
    logic                          out_run_last_reg;

    logic                          sample_acc;
    logic [lsjs_pkg::ANG_W-1:0]    theta_next;
    logic                          kept_next;
    logic                          cord_done;
    lsjs_pkg::coord_t              cord_x;
    lsjs_pkg::coord_t              cord_y;
    logic                          jump_done;
    logic                          jump_over;

    logic [lsjs_pkg::MINP_W-1:0]   need;
    logic [WW-1:0]                 need_w;
    logic [WW-1:0]                 jcnt;
    logic [WW-1:0]                 ecnt;
    logic                          jemit;
    logic                          eemit;
    lsjs_pkg::cnt_t                seg_start_next;
    lsjs_pkg::cnt_t                kept_count_next;

    logic                          out_free;
    logic [2:0]                    pend_low;
    logic [2:0]                    pend_next;

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign sample_acc   = sample.valid && sample.ready;

    // Angle of this sample and the keep test.
    always_comb
    begin
        theta_next = in_scan_reg ? angle_acc_reg : angle_min_reg;
        kept_next  = sample.range_valid && (sample.range_mm >= lsjs_pkg::MIN_RANGE)
                     && (kept_count_reg < lsjs_pkg::CNT_W'(lsjs_pkg::MAX_POINTS));
    end

    lsjs_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cord_start_reg),
        .range_mm (range_reg),
        .theta    (theta_reg),
        .done     (cord_done),
        .x_mm     (cord_x),
        .y_mm     (cord_y)
    );

    lsjs_jump u_jump (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (jump_start_reg),
        .x_mm   (pt_x_reg),
        .y_mm   (pt_y_reg),
        .prev_x (prev_x_reg),
        .prev_y (prev_y_reg),
        .thresh (jump_dist_sq_reg),
        .done   (jump_done),
        .over   (jump_over)
    );

    // Segment bookkeeping: the segment a jump closes, then the one the scan end closes.
    always_comb
    begin
        need            = (min_points_reg == '0) ? lsjs_pkg::MINP_W'(1) : min_points_reg;
        need_w          = WW'(need);
        jcnt            = WW'(kept_count_reg) - WW'(seg_start_reg);
        jemit           = jump_reg && (jcnt != '0) && (jcnt >= need_w);
        seg_start_next  = jump_reg ? kept_count_reg : seg_start_reg;
        kept_count_next = kept_count_reg + lsjs_pkg::CNT_W'(kept_reg);
        ecnt            = WW'(kept_count_next) - WW'(seg_start_next);
        eemit           = end_reg && (kept_count_next > seg_start_next) && (ecnt >= need_w);
    end

    // Pending results leave in order: point, jump segment, end segment.
    always_comb
    begin
        out_free  = !out_valid_reg || result.ready;
        pend_low  = pend_reg & (~pend_reg + 3'd1);
        pend_next = pend_reg & ~pend_low;
    end

    // Sequencer, scan state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_min_reg    <= lsjs_pkg::RST_ANGLE_MIN;
            angle_step_reg   <= lsjs_pkg::RST_ANGLE_STEP;
            jump_dist_sq_reg <= lsjs_pkg::RST_JUMP_DIST_SQ;
            min_points_reg   <= lsjs_pkg::RST_MIN_POINTS;
            angle_acc_reg    <= '0;
            in_scan_reg      <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            kept_count_reg   <= '0;
            seg_start_reg    <= '0;
            state_reg        <= S_IDLE;
            kept_reg         <= 1'b0;
            end_reg          <= 1'b0;
            jump_reg         <= 1'b0;
            cord_start_reg   <= 1'b0;
            jump_start_reg   <= 1'b0;
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cord_start_reg <= 1'b0;
            jump_start_reg <= 1'b0;

            if (cfg.valid)
            begin
                case (cfg.index)
                    lsjs_pkg::CFG_ANGLE_MIN:
                        angle_min_reg <= cfg.data[lsjs_pkg::ANG_W-1:0];
                    lsjs_pkg::CFG_ANGLE_STEP:
                        angle_step_reg <= cfg.data[lsjs_pkg::ANG_W-1:0];
                    lsjs_pkg::CFG_JUMP_DIST_SQ:
                        jump_dist_sq_reg <= cfg.data[lsjs_pkg::JUMP_W-1:0];
                    lsjs_pkg::CFG_MIN_POINTS:
                        min_points_reg <= cfg.data[lsjs_pkg::MINP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_acc)
                    begin
                        angle_acc_reg  <= theta_next + angle_step_reg;
                        in_scan_reg    <= 1'b1;
                        kept_reg       <= kept_next;
                        end_reg        <= sample.scan_end;
                        jump_reg       <= 1'b0;
                        cord_start_reg <= kept_next;
                        state_reg      <= kept_next ? S_CORD : S_DECIDE;
                    end
                end
                S_CORD:
                begin
                    if (cord_done)
                    begin
                        if (kept_count_reg != '0 && cord_x != '0 && cord_y != '0)
                        begin
                            jump_start_reg <= 1'b1;
                            state_reg      <= S_JUMP;
                        end
                        else
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_JUMP:
                begin
                    if (jump_done)
                    begin
                        jump_reg  <= jump_over;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    pend_reg <= {eemit, jemit, kept_reg};
                    if (end_reg)
                    begin
                        angle_acc_reg  <= '0;
                        in_scan_reg    <= 1'b0;
                        prev_x_reg     <= '0;
                        prev_y_reg     <= '0;
                        kept_count_reg <= '0;
                        seg_start_reg  <= '0;
                    end
                    else
                    begin
                        kept_count_reg <= kept_count_next;
                        seg_start_reg  <= seg_start_next;
                        if (kept_reg)
                        begin
                            prev_x_reg <= pt_x_reg;
                            prev_y_reg <= pt_y_reg;
                        end
                    end
                    state_reg <= (kept_reg || eemit) ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pend_reg      <= pend_next;
                        if (pend_next == '0)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Sample, point, segment and output word payload.
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            range_reg <= sample.range_mm;
            theta_reg <= theta_next;
        end
        if (state_reg == S_CORD && cord_done)
        begin
            pt_x_reg <= cord_x;
            pt_y_reg <= cord_y;
        end
        if (state_reg == S_DECIDE)
        begin
            pt_idx_reg <= lsjs_pkg::to_idx(kept_count_reg);
            jfirst_reg <= lsjs_pkg::to_idx(seg_start_reg);
            jlast_reg  <= lsjs_pkg::to_idx(kept_count_reg - 1'b1);
            efirst_reg <= lsjs_pkg::to_idx(seg_start_next);
            elast_reg  <= lsjs_pkg::to_idx(kept_count_next - 1'b1);
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_run_last_reg <= (pend_next == '0);
            if (pend_low[0])
            begin
                out_kind_reg  <= lsjs_pkg::KIND_POINT;
                out_x_reg     <= pt_x_reg;
                out_y_reg     <= pt_y_reg;
                out_idx_reg   <= pt_idx_reg;
                out_first_reg <= '0;
                out_last_reg  <= '0;
            end
            else
            begin
                out_kind_reg  <= lsjs_pkg::KIND_SEG;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_idx_reg   <= '0;
                out_first_reg <= pend_low[1] ? jfirst_reg : efirst_reg;
                out_last_reg  <= pend_low[1] ? jlast_reg : elast_reg;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.point_x     = out_x_reg;
    assign result.point_y     = out_y_reg;
    assign result.point_index = out_idx_reg;
    assign result.seg_first   = out_first_reg;
    assign result.seg_last    = out_last_reg;
    assign result.run_last    = out_run_last_reg;

endmodule

`default_nettype wire

### src/lsjs_cordic.sv
// Iterative CORDIC rotator: range and angle to rounded Cartesian millimetres.
`default_nettype none

module lsjs_cordic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lsjs_pkg::RANGE_W-1:0]  range_mm,
    input  wire logic [lsjs_pkg::ANG_W-1:0]    theta,
    output logic                               done,
    output lsjs_pkg::coord_t                   x_mm,
    output lsjs_pkg::coord_t                   y_mm
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic [1:0] C_RND  = 2'd3;

    localparam int XW = lsjs_pkg::XW;
    localparam int ZW = lsjs_pkg::ZW;

    logic [1:0]                         state_reg;
    logic [lsjs_pkg::STEP_W-1:0]        step_reg;
    logic                               done_reg;
    logic [lsjs_pkg::RANGE_W-1:0]       range_reg;
    logic [lsjs_pkg::ANG_W-1:0]         theta_reg;
    logic signed [XW-1:0]               x_reg;
    logic signed [XW-1:0]               y_reg;
    logic signed [ZW-1:0]               z_reg;
    lsjs_pkg::coord_t                   xm_reg;
    lsjs_pkg::coord_t                   ym_reg;

    logic [47:0]                        prod;
    logic signed [XW-1:0]               x_start;
    logic [31:0]                        zu;
    logic                               fold;
    logic [31:0]                        zf;
    logic signed [XW-1:0]               sh_x;
    logic signed [XW-1:0]               sh_y;
    logic signed [ZW-1:0]               atan_z;
    logic                               last_step;

    // Rounds a Q16 value to millimetres and clamps it to the coordinate range.
    function automatic lsjs_pkg::coord_t to_mm(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + XW'(32768)) >>> 16;
        if (t > XW'(lsjs_pkg::MM_MAX))
            t = XW'(lsjs_pkg::MM_MAX);
        else if (t < -XW'(lsjs_pkg::MM_MAX))
            t = -XW'(lsjs_pkg::MM_MAX);
        return t[lsjs_pkg::COORD_W-1:0];
    endfunction

    // Start vector: scaled range, folded into the right half plane.
    always_comb
    begin
        prod    = {32'd0, range_reg} * {16'd0, lsjs_pkg::GAIN_Q32};
        x_start = $signed({{(XW - 32){1'b0}}, prod[47:16]});
        zu      = {theta_reg, 8'd0};
        fold    = zu[31] ^ zu[30];
        zf      = fold ? {~zu[31], zu[30:0]} : zu;
    end

    // One micro-rotation per cycle through a shared shifter.
    always_comb
    begin
        sh_x      = x_reg >>> step_reg;
        sh_y      = y_reg >>> step_reg;
        atan_z    = $signed({{(ZW - 32){1'b0}}, lsjs_pkg::ATAN_TURNS[step_reg]});
        last_step = (step_reg == lsjs_pkg::STEP_W'(lsjs_pkg::CORDIC_N - 1));
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                        state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                        state_reg <= C_RND;
                end
                C_RND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            range_reg <= range_mm;
            theta_reg <= theta;
        end
        if (state_reg == C_MUL)
        begin
            x_reg <= fold ? -x_start : x_start;
            y_reg <= '0;
            z_reg <= $signed({{(ZW - 32){zf[31]}}, zf});
        end
        else if (state_reg == C_ITER)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - sh_y;
                y_reg <= y_reg + sh_x;
                z_reg <= z_reg - atan_z;
            end
            else
            begin
                x_reg <= x_reg + sh_y;
                y_reg <= y_reg - sh_x;
                z_reg <= z_reg + atan_z;
            end
        end
        if (state_reg == C_RND)
        begin
            xm_reg <= to_mm(x_reg);
            ym_reg <= to_mm(y_reg);
        end
    end

    assign done = done_reg;
    assign x_mm = xm_reg;
    assign y_mm = ym_reg;

endmodule

`default_nettype wire

### src/lsjs_jump.sv
// Jump test: squared distance between two points against a threshold, one square a cycle.
`default_nettype none

module lsjs_jump (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire lsjs_pkg::coord_t              x_mm,
    input  wire lsjs_pkg::coord_t              y_mm,
    input  wire lsjs_pkg::coord_t              prev_x,
    input  wire lsjs_pkg::coord_t              prev_y,
    input  wire logic [lsjs_pkg::JUMP_W-1:0]   thresh,
    output logic                               done,
    output logic                               over
);

    localparam logic [1:0] J_IDLE = 2'd0;
    localparam logic [1:0] J_SQX  = 2'd1;
    localparam logic [1:0] J_SQY  = 2'd2;
    localparam logic [1:0] J_CMP  = 2'd3;

    localparam int DW = lsjs_pkg::DIFF_W;
    localparam int SW = lsjs_pkg::SQ_W;

    logic [1:0]            state_reg;
    logic                  done_reg;
    logic                  over_reg;
    logic signed [DW-1:0]  dx_reg;
    logic signed [DW-1:0]  dy_reg;
    logic [SW-1:0]         sqx_reg;
    logic [SW-1:0]         sqy_reg;

    logic signed [DW-1:0]  mul_op;
    logic signed [SW-1:0]  mul_prod;
    logic [SW:0]           dist_sq;

    // The one multiplier squares dx, then dy.
    always_comb
    begin
        mul_op   = (state_reg == J_SQX) ? dx_reg : dy_reg;
        mul_prod = mul_op * mul_op;
        dist_sq  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    // Sequencer and result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= J_IDLE;
            done_reg  <= 1'b0;
            over_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                J_IDLE:
                begin
                    if (start)
                        state_reg <= J_SQX;
                end
                J_SQX:
                begin
                    state_reg <= J_SQY;
                end
                J_SQY:
                begin
                    state_reg <= J_CMP;
                end
                J_CMP:
                begin
                    over_reg  <= (dist_sq > (SW + 1)'(thresh));
                    done_reg  <= 1'b1;
                    state_reg <= J_IDLE;
                end
                default:
                begin
                    state_reg <= J_IDLE;
                end
            endcase
        end
    end

    // Differences and squares.
    always_ff @(posedge clk)
    begin
        if (state_reg == J_IDLE && start)
        begin
            dx_reg <= DW'(x_mm) - DW'(prev_x);
            dy_reg <= DW'(y_mm) - DW'(prev_y);
        end
        if (state_reg == J_SQX)
            sqx_reg <= mul_prod;
        if (state_reg == J_SQY)
            sqy_reg <= mul_prod;
    end

    assign done = done_reg;
    assign over = over_reg;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench of the laser scan jump segmenter: directed and random scans checked word by word.
module tb;
    import lsjs_pkg::*;

    // Idle patterns of the sample sender and the result receiver.
    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

    // One result word as the block reports it.
    typedef struct {
        logic   result_kind;
        coord_t point_x;
        coord_t point_y;
        idx_t   point_index;
        idx_t   seg_first;
        idx_t   seg_last;
        logic   run_last;
    } word_t;

    logic clk;
    logic rst_n;

    lsjs_in_if  in_if ();
    lsjs_out_if out_if ();
    lsjs_cfg_if cfg_if ();

    laser_scan_jump_segmenter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_if),
        .result (out_if),
        .cfg    (cfg_if)
    );

    // Register copies.
    logic [ANG_W-1:0]  angle_min_r;
    logic [ANG_W-1:0]  angle_step_r;
    logic [JUMP_W-1:0] jump_sq_r;
    logic [MINP_W-1:0] min_pts_r;

    // Scan state: angle of the next sample, previous kept point, counts.
    logic [ANG_W-1:0] angle_next;
    coord_t           prev_x;
    coord_t           prev_y;
    int unsigned      kept_n;
    int unsigned      seg_open_at;
    bit               scan_open;

    // Points and segments still owed by the block, oldest first.
    word_t owed_words[$];

    int    mismatches = 0;
    pace_t pace = PACE_FULL;
    bit    hold_req = 1'b0;
    bit    hold_ack = 1'b0;
    int    hold_left = 0;

    // Clock: 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int src_idle_pct();
        case (pace)
            PACE_SRC_IDLE: return 51;
            PACE_BOTH:     return 6;
            default:       return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct();
        case (pace)
            PACE_SNK_STALL: return 51;
            PACE_BOTH:      return 6;
            default:        return 0;
        endcase
    endfunction

    function automatic void clear_scan();
        angle_next  = '0;
        prev_x      = '0;
        prev_y      = '0;
        kept_n      = 0;
        seg_open_at = 0;
        scan_open   = 1'b0;
    endfunction

    // Q16 value to millimetres: round half up, then saturate.
    function automatic coord_t q16_to_mm(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > MM_MAX)
            r = MM_MAX;
        if (r < -MM_MAX)
            r = -MM_MAX;
        return coord_t'(r);
    endfunction

    // Polar sample to Cartesian millimetres by a rotation-mode CORDIC.
    function automatic void polar_to_mm(input logic [RANGE_W-1:0] rng,
                                        input logic [ANG_W-1:0] theta,
                                        output coord_t xo, output coord_t yo);
        logic [31:0] zu;
        logic [63:0] prod;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        zu   = {theta, 8'h00};
        prod = {48'd0, rng} * {32'd0, GAIN_Q32};
        x    = longint'(prod >> 16);
        y    = 0;
        // Second and third quadrants: turn by half a turn and negate the start vector.
        if (zu[31:30] == 2'd1 || zu[31:30] == 2'd2)
        begin
            zu = zu - 32'h8000_0000;
            x  = -x;
        end
        z = longint'($signed(zu));
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, ATAN_TURNS[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, ATAN_TURNS[i]});
            end
        end
        xo = q16_to_mm(x);
        yo = q16_to_mm(y);
    endfunction

    // Works out the points and segments that one accepted sample causes.
    function automatic void segment_sample(input logic [RANGE_W-1:0] rng, input logic ok,
                                           input logic last_flag);
        word_t            made[$];
        word_t            w;
        logic [ANG_W-1:0] theta;
        coord_t           px;
        coord_t           py;
        longint           ddx;
        longint           ddy;
        longint           d2;
        int unsigned      need;
        need  = (min_pts_r == 0) ? 1 : min_pts_r;
        theta = scan_open ? angle_next : angle_min_r;
        angle_next = theta + angle_step_r;
        scan_open  = 1'b1;
        // Kept sample: emit the point, then test for a jump from the previous one.
        if (ok && rng >= MIN_RANGE && kept_n < MAX_POINTS)
        begin
            polar_to_mm(rng, theta, px, py);
            w    = '{KIND_POINT, px, py, idx_t'(kept_n), idx_t'(0), idx_t'(0), 1'b0};
            made = {made, w};
            if (kept_n > 0 && px != 0 && py != 0)
            begin
                ddx = longint'(px) - longint'(prev_x);
                ddy = longint'(py) - longint'(prev_y);
                d2  = ddx * ddx + ddy * ddy;
                if (d2 > longint'({32'd0, jump_sq_r}))
                begin
                    if (kept_n - seg_open_at >= 1 && kept_n - seg_open_at >= need)
                    begin
                        w    = '{KIND_SEG, coord_t'(0), coord_t'(0), idx_t'(0),
                                 idx_t'(seg_open_at), idx_t'(kept_n - 1), 1'b0};
                        made = {made, w};
                    end
                    seg_open_at = kept_n;
                end
            end
            prev_x = px;
            prev_y = py;
            kept_n++;
        end
        // End of scan closes the open segment and clears the scan.
        if (last_flag)
        begin
            if (kept_n > seg_open_at && kept_n - seg_open_at >= need)
            begin
                w    = '{KIND_SEG, coord_t'(0), coord_t'(0), idx_t'(0),
                         idx_t'(seg_open_at), idx_t'(kept_n - 1), 1'b0};
                made = {made, w};
            end
            clear_scan();
        end
        if (made.size() > 0)
            made[made.size() - 1].run_last = 1'b1;
        owed_words = {owed_words, made};
    endfunction

    // Receiver: random stalls by pace, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= 400;
            out_if.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct());
    end

    // Each accepted result word is compared with the oldest owed word.
    always @(posedge clk)
    begin : check_words
        word_t want;
        word_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = '{out_if.result_kind, out_if.point_x, out_if.point_y, out_if.point_index,
                    out_if.seg_first, out_if.seg_last, out_if.run_last};
            if (owed_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected word: kind %0d x %0d y %0d idx %0d ",
                              "seg %0d..%0d last %0d"},
                             got.result_kind, got.point_x, got.point_y, got.point_index,
                             got.seg_first, got.seg_last, got.run_last);
            end
            else
            begin
                want = owed_words.pop_front();
                if (got.result_kind !== want.result_kind || got.point_x !== want.point_x ||
                    got.point_y !== want.point_y || got.point_index !== want.point_index ||
                    got.seg_first !== want.seg_first || got.seg_last !== want.seg_last ||
                    got.run_last !== want.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word mismatch: expected kind %0d x %0d y %0d idx %0d ",
                                  "seg %0d..%0d last %0d, got kind %0d x %0d y %0d idx %0d ",
                                  "seg %0d..%0d last %0d"},
                                 want.result_kind, want.point_x, want.point_y,
                                 want.point_index, want.seg_first, want.seg_last,
                                 want.run_last, got.result_kind, got.point_x, got.point_y,
                                 got.point_index, got.seg_first, got.seg_last, got.run_last);
                end
            end
        end
    end

    // Sends one sample, with idle cycles ahead of it by pace.
    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic ok,
                               input logic last_flag);
        while ($urandom_range(99) < src_idle_pct())
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.range_mm    <= rng;
        in_if.range_valid <= ok;
        in_if.scan_end    <= last_flag;
        do
            @(posedge clk);
        while (!(in_if.valid && in_if.ready));
        segment_sample(rng, ok, last_flag);
    endtask

    // Stops sending and waits until every owed word has come, then lets a rejected
    // sample finish.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // One register write; the write channel stays valid until cfg_release.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            CFG_ANGLE_MIN:    angle_min_r  = val[ANG_W-1:0];
            CFG_ANGLE_STEP:   angle_step_r = val[ANG_W-1:0];
            CFG_JUMP_DIST_SQ: jump_sq_r    = val[JUMP_W-1:0];
            CFG_MIN_POINTS:   min_pts_r    = val[MINP_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] amin,
                              input logic [CFG_DATA_W-1:0] astep,
                              input logic [CFG_DATA_W-1:0] jump,
                              input logic [CFG_DATA_W-1:0] minp);
        write_reg(CFG_ANGLE_MIN, amin);
        write_reg(CFG_ANGLE_STEP, astep);
        write_reg(CFG_JUMP_DIST_SQ, jump);
        write_reg(CFG_MIN_POINTS, minp);
        cfg_release();
    endtask

    // Range of a random sample: mostly a wandering surface with occasional breaks,
    // some arbitrary and short ranges, some invalid.
    task automatic pick_sample(inout int surf, output logic [RANGE_W-1:0] rng, output logic ok);
        int pick;
        pick = $urandom_range(99);
        ok   = 1'b1;
        if (pick < 75)
        begin
            if ($urandom_range(99) < 15)
                surf = $urandom_range(60, 8000);
            surf = surf + $urandom_range(0, 60) - 30;
            rng  = RANGE_W'(surf);
        end
        else if (pick < 85)
            rng = RANGE_W'($urandom);
        else if (pick < 92)
            rng = RANGE_W'($urandom_range(0, 25));
        else
        begin
            rng = RANGE_W'($urandom);
            ok  = 1'b0;
        end
    endtask

    // Boundary ranges and the validity flag with the reset register values.
    task automatic test_sample_extremes();
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'd19, 1'b1, 1'b0);
        send_sample(16'd20, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'h5555, 1'b1, 1'b0);
        send_sample(16'hAAAA, 1'b1, 1'b1);
        drain();
    endtask

    // Points on the axes at full range, then points just inside every quadrant.
    task automatic test_quadrants();
        set_config(32'h0, 32'h0040_0000, 32'h0, 32'h0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        drain();
        set_config(32'h00FF_FFFF, 32'h0040_0000, 32'h0, 32'h1);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'd30000, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'd20, 1'b1, 1'b1);
        drain();
    endtask

    // Largest jump threshold, and minimum segment sizes that these short scans never reach.
    task automatic test_jump_limits();
        set_config(32'h0015_5555, 32'h000A_AAAA, 32'hFFFF_FFFF, 32'd2048);
        send_sample(16'd1500, 1'b1, 1'b0);
        send_sample(16'd9000, 1'b1, 1'b1);
        drain();
        set_config(32'hFF20_0000, 32'h0000_0400, 32'h0, 32'h0000_0FFF);
        send_sample(16'd800, 1'b1, 1'b0);
        send_sample(16'd4000, 1'b1, 1'b1);
        drain();
    endtask

    // Scans that end with no kept point report nothing.
    task automatic test_empty_scan();
        send_sample(16'd5, 1'b1, 1'b1);
        send_sample(16'd30000, 1'b0, 1'b1);
        drain();
    endtask

    // Registers rewritten inside an open scan; the start angle waits for the next scan.
    task automatic test_midscan_config();
        set_config(32'h0008_0000, 32'h0000_1000, 32'd2500, 32'd2);
        send_sample(16'd1200, 1'b1, 1'b0);
        send_sample(16'd1210, 1'b1, 1'b0);
        drain();
        write_reg(CFG_ANGLE_MIN, 32'h00C0_0000);
        write_reg(CFG_ANGLE_STEP, 32'h0020_0000);
        write_reg(CFG_MIN_POINTS, 32'd1);
        write_reg(CFG_JUMP_DIST_SQ, 32'd0);
        cfg_release();
        send_sample(16'd1220, 1'b1, 1'b0);
        send_sample(16'd1230, 1'b1, 1'b1);
        send_sample(16'd700, 1'b1, 1'b0);
        send_sample(16'd710, 1'b1, 1'b1);
        drain();
    endtask

    // The receiver holds off while the sender keeps offering samples.
    task automatic test_backpressure();
        pace = PACE_FULL;
        set_config($urandom, 32'h0004_0000, 32'd0, 32'd1);
        hold_req <= ~hold_req;
        for (int i = 0; i < 16; i++)
            send_sample(RANGE_W'($urandom_range(20, 60000)), 1'b1, i == 15);
        drain();
    endtask

    // Random scans under one pace, with random registers between scans.
    task automatic random_scans(input pace_t p, input int n);
        int                 sent;
        int                 len;
        int                 surf;
        bit                 broken;
        logic [RANGE_W-1:0] rng;
        logic               ok;
        logic [31:0]        astep;
        logic [31:0]        jump;
        logic [31:0]        minp;
        pace = p;
        sent = 0;
        while (sent < n)
        begin
            drain();
            case ($urandom_range(3))
                0:       astep = 32'd16777216 / $urandom_range(8, 64);
                1:       astep = $urandom_range(0, 4096);
                default: astep = $urandom;
            endcase
            case ($urandom_range(5))
                0:       jump = 32'd0;
                1:       jump = $urandom_range(0, 400);
                2:       jump = $urandom_range(0, 250000);
                3:       jump = $urandom;
                4:       jump = 32'hFFFF_FFFF;
                default: jump = $urandom_range(1000, 40000);
            endcase
            case ($urandom_range(5))
                0:       minp = {$urandom} & 32'hFFFF_F000;
                1:       minp = 32'd2048;
                2:       minp = $urandom;
                default: minp = {$urandom} & 32'hFFFF_F000 | $urandom_range(1, 4);
            endcase
            set_config($urandom, astep, jump, minp);
            len    = $urandom_range(1, 16);
            broken = ($urandom_range(99) < 20);
            surf   = $urandom_range(60, 8000);
            for (int k = 0; k < len; k++)
            begin
                pick_sample(surf, rng, ok);
                if (broken && $urandom_range(1) == 0)
                    ok = 1'b0;
                send_sample(rng, ok, (k == len - 1) && !broken);
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_random();
        random_scans(PACE_FULL, 16);
        random_scans(PACE_SRC_IDLE, 16);
        random_scans(PACE_SNK_STALL, 16);
        random_scans(PACE_BOTH, 16);
    endtask

    // Main sequence.
    initial
    begin
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.range_mm    = '0;
        in_if.range_valid = 1'b0;
        in_if.scan_end    = 1'b0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        angle_min_r       = RST_ANGLE_MIN;
        angle_step_r      = RST_ANGLE_STEP;
        jump_sq_r         = RST_JUMP_DIST_SQ;
        min_pts_r         = RST_MIN_POINTS;
        clear_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_sample_extremes();
        test_quadrants();
        test_jump_limits();
        test_empty_scan();
        test_midscan_config();
        test_backpressure();
        test_random();

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
